// ===== design/sfa_pkg.sv =====
`timescale 1ns / 1ps
package sfa_pkg;
  localparam int SPECTRUM_BINS = 1024;
  localparam int POS_W = $clog2(SPECTRUM_BINS);
  localparam int FRAMES_W = 11;
  localparam logic [FRAMES_W-1:0] MAX_FRAMES = 11'd1024;
  localparam int SUM_W = 42;
  localparam int SPECTRA_W = 26;
  localparam int SAMPLES_W = 42;
  localparam logic [7:0] FLAG_UNKNOWN = 8'd63;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);
  localparam int DIV_CNT_W = $clog2(SUM_W + 1);

  typedef struct packed {
    logic signed [31:0]   bin_value;
    logic                 last;
    logic [POS_W-1:0]     pos;
    logic                 restart;
    logic                 closing;
    logic [FRAMES_W-1:0]  frames;
    logic [7:0]           sideband;
    logic [7:0]           polarization;
    logic [31:0]          acq_sec;
    logic [31:0]          acq_rate;
    logic [47:0]          leading_index;
    logic [SPECTRA_W-1:0] spectra_total;
    logic [SAMPLES_W-1:0] samples_total;
  } cmd_t;

  typedef enum logic [1:0] {ST_IDLE, ST_SUM, ST_DIV, ST_OUT} back_state_t;
endpackage

// ===== design/sfa_front.sv =====
`timescale 1ns / 1ps
module sfa_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic [10:0]         cfg_data,
  input  logic                in_valid,
  input  logic                in_last,
  input  logic [191:0]        in_data,
  input  logic                push_ready,
  output logic                push,
  output sfa_pkg::cmd_t       cmd
);
  import sfa_pkg::*;

  logic [FRAMES_W-1:0]  frames_to_average;
  logic                 in_frame;
  logic [POS_W-1:0]     pos;
  logic [FRAMES_W-1:0]  frames_done;
  logic                 restart;
  logic                 closing;
  logic [7:0]           held_sideband;
  logic [7:0]           held_polarization;
  logic [31:0]          held_acq_sec;
  logic [31:0]          held_acq_rate;
  logic [47:0]          held_leading_index;
  logic [SPECTRA_W-1:0] spectra_total;
  logic [SAMPLES_W-1:0] samples_total;

  logic [7:0]           sb, pol;
  logic [31:0]          ss, sr, samples;
  logic [47:0]          li;
  logic [15:0]          sc, fl;
  logic                 match;
  logic [FRAMES_W-1:0]  eff, fd_inc;
  logic [SPECTRA_W:0]   spectra_sum;
  logic [SAMPLES_W:0]   samples_sum;
  logic [POS_W-1:0]     f_pos;

  assign sb = in_data[39:32];
  assign pol = in_data[47:40];
  assign ss = in_data[79:48];
  assign sr = in_data[111:80];
  assign li = in_data[159:112];
  assign sc = in_data[175:160];
  assign fl = in_data[191:176];
  assign samples = 32'(sc) * 32'(fl);
  assign push = in_valid && push_ready;

  always_comb begin
    match = (frames_done != '0) && (sb == held_sideband) && (pol == held_polarization)
            && (ss == held_acq_sec) && (sr == held_acq_rate)
            && (li >= held_leading_index);
    eff = (frames_to_average == '0) ? FRAMES_W'(1) :
          (frames_to_average > MAX_FRAMES) ? MAX_FRAMES : frames_to_average;
    fd_inc = frames_done + FRAMES_W'(1);
    spectra_sum = {1'b0, spectra_total} + (SPECTRA_W+1)'(sc);
    samples_sum = {1'b0, samples_total} + (SAMPLES_W+1)'(samples);
    f_pos = in_frame ? pos : '0;
    cmd.bin_value = in_data[31:0];
    cmd.last = in_last;
    cmd.pos = f_pos;
    if (in_frame) begin
      cmd.restart = restart;
      cmd.frames = frames_done;
      cmd.sideband = held_sideband;
      cmd.polarization = held_polarization;
      cmd.acq_sec = held_acq_sec;
      cmd.acq_rate = held_acq_rate;
      cmd.leading_index = held_leading_index;
      cmd.spectra_total = spectra_total;
      cmd.samples_total = samples_total;
      cmd.closing = closing;
    end else if (match) begin
      cmd.restart = 1'b0;
      cmd.frames = fd_inc;
      cmd.sideband = held_sideband;
      cmd.polarization = held_polarization;
      cmd.acq_sec = held_acq_sec;
      cmd.acq_rate = held_acq_rate;
      cmd.leading_index = held_leading_index;
      cmd.spectra_total = spectra_sum[SPECTRA_W] ? '1 : spectra_sum[SPECTRA_W-1:0];
      cmd.samples_total = samples_sum[SAMPLES_W] ? '1 : samples_sum[SAMPLES_W-1:0];
      cmd.closing = fd_inc >= eff;
    end else begin
      cmd.restart = 1'b1;
      cmd.frames = FRAMES_W'(1);
      cmd.sideband = sb;
      cmd.polarization = pol;
      cmd.acq_sec = ss;
      cmd.acq_rate = sr;
      cmd.leading_index = li;
      cmd.spectra_total = SPECTRA_W'(sc);
      cmd.samples_total = SAMPLES_W'(samples);
      cmd.closing = FRAMES_W'(1) >= eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_to_average <= FRAMES_W'(1);
      in_frame <= 1'b0;
      pos <= '0;
      frames_done <= '0;
      held_sideband <= FLAG_UNKNOWN;
      held_polarization <= FLAG_UNKNOWN;
    end else begin
      if (cfg_valid) frames_to_average <= cfg_data;
      if (push) begin
        restart <= cmd.restart;
        closing <= cmd.closing;
        held_sideband <= cmd.sideband;
        held_polarization <= cmd.polarization;
        held_acq_sec <= cmd.acq_sec;
        held_acq_rate <= cmd.acq_rate;
        held_leading_index <= cmd.leading_index;
        spectra_total <= cmd.spectra_total;
        samples_total <= cmd.samples_total;
        in_frame <= !in_last;
        pos <= (in_last || f_pos == POS_W'(SPECTRUM_BINS - 1)) ? '0 : f_pos + POS_W'(1);
        frames_done <= (in_last && cmd.closing) ? '0 : cmd.frames;
      end
    end
  end
endmodule

// ===== design/sfa_fifo.sv =====
`timescale 1ns / 1ps
module sfa_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sfa_pkg::cmd_t push_cmd,
  output logic          not_full,
  input  logic          pop,
  output logic          not_empty,
  output sfa_pkg::cmd_t head
);
  import sfa_pkg::*;

  cmd_t               slots [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [FIFO_AW:0]   count;

  assign not_full = count != (FIFO_AW+1)'(FIFO_DEPTH);
  assign not_empty = count != '0;
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + FIFO_AW'(1);
      if (pop) rd_ptr <= rd_ptr + FIFO_AW'(1);
      count <= count + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
    end
  end
endmodule

// ===== design/sfa_back.sv =====
`timescale 1ns / 1ps
module sfa_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          avail,
  input  sfa_pkg::cmd_t head,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          out_last,
  output logic [231:0]  out_data
);
  import sfa_pkg::*;

  back_state_t          state, state_next;
  logic signed [SUM_W-1:0] sums [SPECTRUM_BINS];
  logic signed [SUM_W-1:0] rd_sum, sum;
  cmd_t                 cur;
  logic [SUM_W-1:0]     dq;
  logic [FRAMES_W-1:0]  rem;
  logic [FRAMES_W:0]    trial;
  logic                 ge, neg;
  logic [DIV_CNT_W-1:0] cnt;
  logic [31:0]          avg;

  assign sum = cur.restart ? SUM_W'(cur.bin_value) : rd_sum + SUM_W'(cur.bin_value);
  assign trial = {rem, dq[SUM_W-1]};
  assign ge = trial >= {1'b0, cur.frames};
  assign avg = neg ? -dq[31:0] : dq[31:0];
  assign out_last = cur.last;
  assign out_data = {4'd0, cur.samples_total, cur.spectra_total, cur.leading_index,
                     cur.acq_rate, cur.acq_sec, cur.polarization, cur.sideband,
                     avg};

  always_comb begin
    state_next = state;
    pop = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (avail) begin
          pop = 1'b1;
          state_next = ST_SUM;
        end
      end
      ST_SUM: state_next = cur.closing ? ST_DIV : ST_IDLE;
      ST_DIV: if (cnt == DIV_CNT_W'(1)) state_next = ST_OUT;
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
      rd_sum <= sums[head.pos];
    end
    if (state == ST_SUM) begin
      sums[cur.pos] <= sum;
      neg <= sum[SUM_W-1];
      dq <= sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
      rem <= '0;
      cnt <= DIV_CNT_W'(SUM_W);
    end
    if (state == ST_DIV) begin
      rem <= ge ? FRAMES_W'(trial - {1'b0, cur.frames}) : trial[FRAMES_W-1:0];
      dq <= {dq[SUM_W-2:0], ge};
      cnt <= cnt - DIV_CNT_W'(1);
    end
  end
endmodule

// ===== design/spectrum_frame_averager.sv =====
`timescale 1ns / 1ps
// Path: an accepted bin is queued, then popped with its sum read, then written into its sum;
// a bin of a closing frame then runs the 42-step serial divider before its result shows.
// The back end takes no new bin until it is through with the last one (its divide and a
// stalled output included), set by the single-item read-modify-write and divider; a 4-item queue
// absorbs bursts. Reset: rst synchronous, active high; clears control and queue, frame count 1.
module spectrum_frame_averager (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [10:0]  cfg_data,   // frames_to_average
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [191:0] s_tdata,    // bin_value, sideband, polarization, acq_sec,
                                   // acq_rate, leading_index, spectra_count, fft_length
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [231:0] m_tdata,    // average_value, out_sideband, out_polarization,
                                   // out_acq_sec, out_acq_rate, out_leading_index,
                                   // total_spectra, total_samples, zero fill
  output logic         m_tlast
);
  import sfa_pkg::*;

  cmd_t push_cmd, head;
  logic push, not_full, pop, not_empty;

  assign cfg_ready = 1'b1;
  assign s_tready = not_full;

  sfa_front u_front (
    .clk(clk), .rst(rst), .cfg_valid(cfg_valid), .cfg_data(cfg_data),
    .in_valid(s_tvalid), .in_last(s_tlast), .in_data(s_tdata),
    .push_ready(not_full), .push(push), .cmd(push_cmd)
  );

  sfa_fifo u_fifo (
    .clk(clk), .rst(rst), .push(push), .push_cmd(push_cmd), .not_full(not_full),
    .pop(pop), .not_empty(not_empty), .head(head)
  );

  sfa_back u_back (
    .clk(clk), .rst(rst), .avail(not_empty), .head(head), .pop(pop),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_last(m_tlast), .out_data(m_tdata)
  );
endmodule

// ===== design/sfa_checker.sv =====
`timescale 1ns / 1ps
module sfa_checker (
  input logic         clk,
  input logic         rst,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [231:0] m_tdata,
  input logic         m_tlast
);
  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped while stalled");
  a_data_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result shown after reset");
  a_gap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready |=> !m_tvalid) else $error("results back to back");
endmodule

bind spectrum_frame_averager sfa_checker u_sfa_checker (
  .clk(clk), .rst(rst), .m_tvalid(m_tvalid), .m_tready(m_tready),
  .m_tdata(m_tdata), .m_tlast(m_tlast)
);
